[hdl/f32as_pkg.sv]
// Package for the single-precision add/subtract unit.
// Holds field widths, constants and the inter-stage struct types; no dependencies.
package f32as_pkg;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned SigW  = 24;
  localparam logic [SigW-1:0] HiddenOne = 24'h800000;
  localparam logic CmdAdd = 1'b0;
  localparam logic CmdSub = 1'b1;

  // after unpack/order/align
  typedef struct packed {
    logic            eff_sub;
    logic            cancel;
    logic            sign;
    logic [ExpW-1:0] e_big;
    logic [SigW-1:0] m_big;
    logic [SigW-1:0] m_sml_sh;
    logic            guard;
  } align_t;

  // after add/subtract
  typedef struct packed {
    logic            eff_sub;
    logic            cancel;
    logic            sign;
    logic [ExpW-1:0] e_big;
    logic [SigW:0]   sig;
  } sum_t;
endpackage

[hdl/float32_add_subtract_unit.sv]
// Top level of the single-precision truncating add/subtract unit.
// Depends on f32as_pkg, f32as_align, f32as_addsub, f32as_norm.
//
// channel | ports                                        | transfer
// input   | command_i, operand_a_i, operand_b_i          | start_i && !busy_o
// result  | sum_word_o, range_error_o                    | done_o (one cycle)
//
// Three register stages: align, add/subtract, normalize. done_o is the valid
// bit of the last stage, which moves in step with the normalize register;
// one item enters every cycle.
// busy_o is held low: the result side cannot stall, so the pipe never holds.
// Reset clears the stage valid bits only.
module float32_add_subtract_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        done_o,
  output logic [31:0] sum_word_o,
  output logic        range_error_o
);
  f32as_pkg::align_t align_d, align_q;
  f32as_pkg::sum_t   sum_d, sum_q;
  logic [31:0]       word_d, word_q;
  logic              rerr_d, rerr_q;
  logic [2:0]        vld_q;

  assign busy_o = 1'b0;

  f32as_align u_align (.command_i, .operand_a_i, .operand_b_i, .align_o(align_d));
  f32as_addsub u_addsub (.align_i(align_q), .sum_o(sum_d));
  f32as_norm u_norm (.sum_i(sum_q), .sum_word_o(word_d), .range_error_o(rerr_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i && !busy_o};
    end
  end

  always_ff @(posedge clk_i) begin
    align_q <= align_d;
    sum_q   <= sum_d;
    word_q  <= word_d;
    rerr_q  <= rerr_d;
  end

  assign done_o        = vld_q[2];
  assign sum_word_o    = word_q;
  assign range_error_o = rerr_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##2 done_o) else $error("result lost");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[1])) else $error("spurious result");
  a_cancel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[1] && sum_q.eff_sub && sum_q.cancel) |=> (sum_word_o == 32'd0 && !range_error_o))
    else $error("cancel not zero");
endmodule

[hdl/f32as_align.sv]
// Stage 1: unpack, order magnitudes, align the smaller significand.
// Depends on f32as_pkg.
module f32as_align (
  input  logic                 command_i,
  input  logic [31:0]          operand_a_i,
  input  logic [31:0]          operand_b_i,
  output f32as_pkg::align_t    align_o
);
  logic                        sa, sb, b_bigger;
  logic [f32as_pkg::ExpW-1:0]  ea, eb, e_sml, d;
  logic [f32as_pkg::FracW-1:0] fa, fb;
  logic [f32as_pkg::SigW-1:0]  m_sml;
  logic [4:0]                  dg;

  always_comb begin
    sa = operand_a_i[31];
    sb = operand_b_i[31] ^ (command_i == f32as_pkg::CmdSub);
    ea = operand_a_i[30:23];
    eb = operand_b_i[30:23];
    fa = operand_a_i[22:0];
    fb = operand_b_i[22:0];
    b_bigger = (eb > ea) || ((eb == ea) && (fb > fa));
    align_o.e_big = b_bigger ? eb : ea;
    e_sml         = b_bigger ? ea : eb;
    align_o.m_big = {1'b1, b_bigger ? fb : fa};
    m_sml         = {1'b1, b_bigger ? fa : fb};
    d = align_o.e_big - e_sml;
    align_o.m_sml_sh = (d >= 8'd24) ? '0 : (m_sml >> d[4:0]);
    dg = d[4:0] - 5'd1;
    align_o.guard = (d != 8'd0) && (d <= 8'd24) && m_sml[dg];
    align_o.eff_sub = (sa != sb);
    align_o.cancel  = (ea == eb) && (fa == fb);
    align_o.sign    = sa ^ ((sa != sb) && b_bigger);
  end
endmodule

[hdl/f32as_addsub.sv]
// Stage 2: magnitude add or subtract with the truncation decrement.
// Depends on f32as_pkg.
module f32as_addsub (
  input  f32as_pkg::align_t align_i,
  output f32as_pkg::sum_t   sum_o
);
  logic [f32as_pkg::SigW:0] diff;

  always_comb begin
    diff = {1'b0, align_i.m_big} - {1'b0, align_i.m_sml_sh};
    if (align_i.guard && (diff > 25'd1)) diff = diff - 25'd1;
    sum_o.eff_sub = align_i.eff_sub;
    sum_o.cancel  = align_i.cancel;
    sum_o.sign    = align_i.sign;
    sum_o.e_big   = align_i.e_big;
    sum_o.sig     = align_i.eff_sub ? diff
                                    : ({1'b0, align_i.m_big} + {1'b0, align_i.m_sml_sh});
  end
endmodule

[hdl/f32as_norm.sv]
// Stage 3: normalize, form the exponent and the range flag, pack.
// Depends on f32as_pkg.
module f32as_norm (
  input  f32as_pkg::sum_t sum_i,
  output logic [31:0]     sum_word_o,
  output logic            range_error_o
);
  logic [4:0]  lz;
  logic [23:0] sh;
  logic [9:0]  ex;
  logic [22:0] fr;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (sum_i.sig[i]) lz = 5'(23 - i);
    end
    if (!sum_i.eff_sub) begin
      if (sum_i.sig[24]) begin
        fr = sum_i.sig[23:1];
        ex = {2'b00, sum_i.e_big} + 10'd1;
      end else begin
        fr = sum_i.sig[22:0];
        ex = {2'b00, sum_i.e_big};
      end
      sh = '0;
    end else begin
      sh = sum_i.sig[23:0] << lz;
      fr = sh[22:0];
      ex = {2'b00, sum_i.e_big} - {5'd0, lz};
    end
    if (sum_i.eff_sub && sum_i.cancel) begin
      sum_word_o    = '0;
      range_error_o = 1'b0;
    end else begin
      sum_word_o    = {sum_i.sign, ex[7:0], fr};
      range_error_o = ex[9] || (ex == 10'd0) || (ex > 10'd254);
    end
  end
endmodule
